/* hdl/rsp_pkg.sv */
// Shared types and constants for the rlogin stream parser.
package rsp_pkg;

    typedef enum logic [3:0] {
        PH_FIRST_NUL   = 4'd0,
        PH_CLIENT_NAME = 4'd1,
        PH_SERVER_NAME = 4'd2,
        PH_TERMINAL    = 4'd3,
        PH_SERVER_ACK  = 4'd4,
        PH_CTRL_FF2    = 4'd5,
        PH_WIN_S1      = 4'd6,
        PH_WIN_S2      = 4'd7,
        PH_WIN_SKIP    = 4'd8,
        PH_LINE        = 4'd9,
        PH_UNKNOWN     = 4'd10,
        PH_REJECTED    = 4'd11
    } phase_t;

    typedef enum logic [2:0] {
        K_CLIENT_NAME  = 3'd0,
        K_SERVER_NAME  = 3'd1,
        K_TERMINAL     = 3'd2,
        K_TEXT         = 3'd3,
        K_LINE_END     = 3'd4,
        K_BAD_PROLOG   = 3'd5,
        K_AFTER_REJECT = 3'd6
    } kind_t;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_S   = 8'h73;
    localparam logic [7:0] CHAR_FF  = 8'hFF;

    // Bytes of window-size payload after FF FF 's' 's'
    localparam logic [3:0] WINDOW_PAYLOAD_BYTES = 4'd8;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
    } result_t;

    // Results of one accepted byte, handed to the output queue
    typedef struct packed {
        logic                           valid;
        logic [1:0]                     count;
        result_t [MAX_RESULTS-1:0]      res;
    } load_t;

endpackage

/* hdl/rsp_core.sv */
// Parser state registers and the per-byte step logic.
module rsp_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data,
    input  logic            in_xfer,
    input  logic [7:0]      data_byte,
    input  logic            stream_midway,
    input  logic            peer_rejected,
    output rsp_pkg::load_t  load
);
    import rsp_pkg::*;

    typedef struct packed {
        phase_t     phase;
        phase_t     resume;
        logic [7:0] prev;
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } line_t;

    // Line-mode handling of one byte, starting from phase p_in
    function automatic line_t line_step(
        input phase_t     p_in,
        input phase_t     rs,
        input logic [7:0] c,
        input logic       rej,
        input logic [7:0] pb,
        input logic       client
    );
        line_t   o;
        phase_t  p;
        logic    e_after;
        logic    e_main;
        result_t m;
        begin
            p       = p_in;
            o.resume = rs;
            e_after = 1'b0;
            e_main  = 1'b0;
            m.kind  = K_TEXT;
            m.value = c;
            if (p == PH_LINE && rej)
            begin
                e_after = 1'b1;
                p       = PH_UNKNOWN;
            end
            if (c == CHAR_LF || c == CHAR_CR)
            begin
                // fold CR LF into one line end
                if (!(c == CHAR_LF && pb == CHAR_CR))
                begin
                    e_main  = 1'b1;
                    m.kind  = K_LINE_END;
                    m.value = 8'h00;
                end
            end
            else if (c == CHAR_FF && client && p == PH_LINE)
            begin
                o.resume = p;
                p        = PH_CTRL_FF2;
            end
            else
            begin
                e_main = 1'b1;
            end
            o.phase      = p;
            o.prev       = c;
            o.count      = {1'b0, e_after} + {1'b0, e_main};
            o.r0.kind    = e_after ? K_AFTER_REJECT : m.kind;
            o.r0.value   = e_after ? 8'h00 : m.value;
            o.r1         = m;
            return o;
        end
    endfunction

    logic       client_reg;
    phase_t     phase_reg,  phase_next;
    phase_t     resume_reg, resume_next;
    logic [3:0] skip_reg,   skip_next;
    logic [7:0] prev_reg,   prev_next;

    phase_t     line_in;
    line_t      lr;
    load_t      ld;

    always_comb
    begin
        unique case (phase_reg)
            PH_CTRL_FF2:                        line_in = resume_reg;
            PH_LINE, PH_UNKNOWN, PH_REJECTED:   line_in = phase_reg;
            default:                            line_in = PH_UNKNOWN;
        endcase
    end

    assign lr = line_step(line_in, resume_reg, data_byte, peer_rejected, prev_reg,
                          client_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        resume_next = resume_reg;
        skip_next   = skip_reg;
        prev_next   = prev_reg;
        ld          = '0;
        ld.valid    = in_xfer;

        unique case (phase_reg)
            PH_FIRST_NUL:
            begin
                if (stream_midway)
                begin
                    phase_next  = lr.phase;
                    resume_next = lr.resume;
                    prev_next   = lr.prev;
                    ld.count    = lr.count;
                    ld.res[0]   = lr.r0;
                    ld.res[1]   = lr.r1;
                end
                else if (data_byte == CHAR_NUL)
                begin
                    phase_next = PH_CLIENT_NAME;
                end
                else
                begin
                    ld.count            = 2'd1;
                    ld.res[0].kind      = K_BAD_PROLOG;
                    ld.res[0].value     = 8'h00;
                    phase_next          = PH_UNKNOWN;
                end
            end
            PH_CLIENT_NAME, PH_SERVER_NAME, PH_TERMINAL:
            begin
                ld.count        = 2'd1;
                ld.res[0].value = data_byte;
                unique case (phase_reg)
                    PH_CLIENT_NAME: ld.res[0].kind = K_CLIENT_NAME;
                    PH_SERVER_NAME: ld.res[0].kind = K_SERVER_NAME;
                    default:        ld.res[0].kind = K_TERMINAL;
                endcase
                if (data_byte == CHAR_NUL)
                begin
                    unique case (phase_reg)
                        PH_CLIENT_NAME: phase_next = PH_SERVER_NAME;
                        PH_SERVER_NAME: phase_next = PH_TERMINAL;
                        default:        phase_next = PH_LINE;
                    endcase
                end
            end
            PH_SERVER_ACK:
            begin
                if (stream_midway)
                begin
                    phase_next  = lr.phase;
                    resume_next = lr.resume;
                    prev_next   = lr.prev;
                    ld.count    = lr.count;
                    ld.res[0]   = lr.r0;
                    ld.res[1]   = lr.r1;
                end
                else
                begin
                    phase_next = (data_byte == CHAR_NUL) ? PH_LINE : PH_REJECTED;
                end
            end
            PH_CTRL_FF2:
            begin
                if (data_byte == CHAR_FF)
                begin
                    phase_next = PH_WIN_S1;
                end
                else
                begin
                    // replay the lone FF, then handle this byte in the resume phase
                    phase_next      = lr.phase;
                    resume_next     = lr.resume;
                    prev_next       = lr.prev;
                    ld.count        = lr.count + 2'd1;
                    ld.res[0].kind  = K_TEXT;
                    ld.res[0].value = CHAR_FF;
                    ld.res[1]       = lr.r0;
                    ld.res[2]       = lr.r1;
                end
            end
            PH_WIN_S1, PH_WIN_S2:
            begin
                if (data_byte == CHAR_S)
                begin
                    if (phase_reg == PH_WIN_S1)
                    begin
                        phase_next = PH_WIN_S2;
                    end
                    else
                    begin
                        phase_next = PH_WIN_SKIP;
                        skip_next  = WINDOW_PAYLOAD_BYTES;
                    end
                end
                else
                begin
                    // broken sequence: give back what was held, drop this byte
                    phase_next      = PH_UNKNOWN;
                    ld.res[0].kind  = K_TEXT;
                    ld.res[0].value = CHAR_FF;
                    ld.res[1].kind  = K_TEXT;
                    ld.res[1].value = CHAR_FF;
                    ld.res[2].kind  = K_TEXT;
                    ld.res[2].value = CHAR_S;
                    if (phase_reg == PH_WIN_S2)
                    begin
                        ld.count  = 2'd3;
                        prev_next = CHAR_S;
                    end
                    else
                    begin
                        ld.count  = 2'd2;
                        prev_next = CHAR_FF;
                    end
                end
            end
            PH_WIN_SKIP:
            begin
                if (skip_reg <= 4'd1)
                begin
                    skip_next  = 4'd0;
                    phase_next = resume_reg;
                end
                else
                begin
                    skip_next = skip_reg - 4'd1;
                end
            end
            default:
            begin
                phase_next  = lr.phase;
                resume_next = lr.resume;
                prev_next   = lr.prev;
                ld.count    = lr.count;
                ld.res[0]   = lr.r0;
                ld.res[1]   = lr.r1;
            end
        endcase
    end

    assign load = ld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            client_reg <= 1'b1;
            phase_reg  <= PH_FIRST_NUL;
            resume_reg <= PH_FIRST_NUL;
            skip_reg   <= 4'd0;
            prev_reg   <= 8'h00;
        end
        else if (cfg_wr_en)
        begin
            // restart for the newly selected side
            client_reg <= cfg_wr_data;
            phase_reg  <= cfg_wr_data ? PH_FIRST_NUL : PH_SERVER_ACK;
            resume_reg <= cfg_wr_data ? PH_FIRST_NUL : PH_SERVER_ACK;
            skip_reg   <= 4'd0;
            prev_reg   <= 8'h00;
        end
        else if (in_xfer)
        begin
            phase_reg  <= phase_next;
            resume_reg <= resume_next;
            skip_reg   <= skip_next;
            prev_reg   <= prev_next;
        end
    end

endmodule

/* hdl/rsp_outq.sv */
// Three-slot result queue that hands results out one transfer at a time.
module rsp_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  rsp_pkg::load_t  load,
    output logic            in_free,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      kind,
    output logic [7:0]      value,
    output logic            last
);
    import rsp_pkg::*;

    result_t [MAX_RESULTS-1:0] slot_reg, slot_next;
    logic [1:0]                cnt_reg,  cnt_next;
    logic                      out_xfer;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_xfer  = out_valid && !out_stall;
    // free when empty, or when the final pending result leaves now
    assign in_free   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_xfer);

    assign kind  = slot_reg[0].kind;
    assign value = slot_reg[0].value;
    assign last  = (cnt_reg == 2'd1);

    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (out_xfer)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
        if (load.valid)
        begin
            slot_next = load.res;
            cnt_next  = load.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

/* hdl/rlogin_stream_parser_top.sv */
// Top level of the rlogin stream parser.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   data_byte, stream_midway, peer_rejected
//  out      source     out_valid / out_stall kind, value, last
//  cfg      sink       cfg_wr_en             cfg_wr_data (is_client_side)
//
// A byte is parsed in the cycle it is taken and its results land in a
// three-slot queue, seen at the outputs the next cycle.
// A byte with more than one result holds the input until its final result
// is leaving the one-per-transfer output queue.
// Reset selects the client side; a configuration write restarts the parser.
// Output stall holds the queue head and stalls the input while a result is pending.
module rlogin_stream_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       stream_midway,
    input  logic       peer_rejected,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] value,
    output logic       last
);
    import rsp_pkg::*;

    load_t load;
    logic  in_free;
    logic  in_xfer;

    assign in_stall = !in_free;
    assign in_xfer  = in_valid && in_free;

    rsp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_xfer       (in_xfer),
        .data_byte     (data_byte),
        .stream_midway (stream_midway),
        .peer_rejected (peer_rejected),
        .load          (load)
    );

    rsp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .in_free   (in_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .value     (value),
        .last      (last)
    );

endmodule

/* hdl/rsp_checker.sv */
// Port-level checks for the rlogin stream parser, bound to the top level.
module rsp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] kind,
    input logic [7:0] value,
    input logic       last
);
    import rsp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable({kind, value, last}))
        else $error("stalled result changed");

    // more results of the same byte pending: no new byte may enter
    a_pending_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input taken while results still pending");

    // empty queue always takes a byte
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty queue");

    // marker kinds carry no byte
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == K_LINE_END || kind == K_BAD_PROLOG || kind == K_AFTER_REJECT)
        |-> value == 8'h00)
        else $error("marker result with non-zero value");

endmodule

bind rlogin_stream_parser_top rsp_checker u_rsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .value     (value),
    .last      (last)
);
